/* sv/ptbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptbd_pkg;

    localparam int BLOB_BYTES_W = 20;
    localparam int JOBQ_DEPTH   = 4;
    localparam int OUTQ_DEPTH   = 8;
    localparam int PREFIX_LEN   = 7;

    localparam logic [15:0] CATALOG_MAGIC = 16'h5754;

    // input operation codes
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_BYTE    = 2'd2;

    // result kinds
    localparam logic KIND_TEXEL = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // end-of-parse status codes
    localparam logic [2:0] ST_ALL_PARSED = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ST_ZERO_COUNT = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
    localparam logic [2:0] ST_BLOB_ENDED = 3'd5;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic [7:0] palette_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] color;
        logic [15:0] entry_index;
        logic [15:0] texel_index;
        logic        entry_done;
        logic [2:0]  status;
        logic [15:0] entries_found;
        logic        last_of_run;
    } out_item_t;

    // work handed from the parser to the palette side
    typedef struct packed {
        logic        is_write;
        logic        has_texel;
        logic        has_end;
        logic        zero_color;
        logic [7:0]  addr;
        logic [23:0] rgb;
        logic [15:0] entry_index;
        logic [15:0] texel_index;
        logic        entry_done;
        logic [2:0]  status;
        logic [15:0] entries_found;
    } job_t;

    function automatic logic [7:0] sprite_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h73; // s
            3'd1:    c = 8'h70; // p
            3'd2:    c = 8'h72; // r
            3'd3:    c = 8'h69; // i
            3'd4:    c = 8'h74; // t
            3'd5:    c = 8'h65; // e
            3'd6:    c = 8'h5f; // _
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] weapon_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h77; // w
            3'd1:    c = 8'h65; // e
            3'd2:    c = 8'h61; // a
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h6f; // o
            3'd5:    c = 8'h6e; // n
            3'd6:    c = 8'h5f; // _
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/ptbd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptbd_front #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int POSITION_BITS   = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire ptbd_pkg::in_item_t                item,
    input  wire logic [ptbd_pkg::BLOB_BYTES_W-1:0] blob_bytes,
    output ptbd_pkg::job_t                         job,
    output logic                                   job_valid
);

    localparam int CW = ((POSITION_BITS > ptbd_pkg::BLOB_BYTES_W) ?
                         POSITION_BITS : ptbd_pkg::BLOB_BYTES_W) + 2;

    typedef enum logic [2:0] {
        PH_IDLE, PH_MAGIC, PH_COUNT, PH_NAMELEN, PH_NAME, PH_TCOUNT, PH_TEXELS
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [7:0]               low_hold_reg, low_hold_next;
    logic [15:0]              field_rem_reg, field_rem_next;
    logic [15:0]              expected_reg, expected_next;
    logic [15:0]              parsed_reg, parsed_next;
    logic [15:0]              texel_cnt_reg, texel_cnt_next;
    logic [2:0]               name_cnt_reg, name_cnt_next;
    logic                     sprite_reg, sprite_next;
    logic                     weapon_reg, weapon_next;
    logic                     transp_reg, transp_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [CW-1:0]            size_w, pos_w, pn_w;
    logic                     rem_lt2;
    logic [15:0]              rem_dec, value, parsed_inc;
    logic [2:0]               name_cnt_inc;
    logic                     sprite_upd, weapon_upd;

    always_comb
    begin
        pos_inc      = pos_reg + 1'b1;
        size_w       = CW'(blob_bytes);
        pos_w        = CW'(pos_reg);
        pn_w         = CW'(pos_inc);
        rem_lt2      = (size_w == pn_w) || (size_w == pn_w + 1'b1);
        rem_dec      = field_rem_reg - 1'b1;
        value        = {item.byte_value, low_hold_reg};
        parsed_inc   = parsed_reg + 1'b1;
        name_cnt_inc = name_cnt_reg;
        sprite_upd   = sprite_reg;
        weapon_upd   = weapon_reg;

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        low_hold_next  = low_hold_reg;
        field_rem_next = field_rem_reg;
        expected_next  = expected_reg;
        parsed_next    = parsed_reg;
        texel_cnt_next = texel_cnt_reg;
        name_cnt_next  = name_cnt_reg;
        sprite_next    = sprite_reg;
        weapon_next    = weapon_reg;
        transp_next    = transp_reg;

        job       = '0;
        job_valid = 1'b0;
        job.entries_found = parsed_reg;

        if (accept)
        begin
            unique case (item.operation)
                ptbd_pkg::OP_PALETTE:
                begin
                    if ({1'b0, item.palette_index} < 9'(PALETTE_ENTRIES))
                    begin
                        job_valid    = 1'b1;
                        job.is_write = 1'b1;
                        job.addr     = item.palette_index;
                        job.rgb      = {item.red, item.green, item.blue};
                    end
                end
                ptbd_pkg::OP_START:
                begin
                    pos_next       = '0;
                    low_hold_next  = '0;
                    field_rem_next = '0;
                    expected_next  = '0;
                    parsed_next    = '0;
                    texel_cnt_next = '0;
                    name_cnt_next  = '0;
                    sprite_next    = 1'b1;
                    weapon_next    = 1'b1;
                    transp_next    = 1'b0;
                    if (blob_bytes < ptbd_pkg::BLOB_BYTES_W'(4))
                    begin
                        job_valid         = 1'b1;
                        job.has_end       = 1'b1;
                        job.status        = ptbd_pkg::ST_SHORT;
                        job.entries_found = '0;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        phase_next     = PH_MAGIC;
                        field_rem_next = 16'd2;
                    end
                end
                ptbd_pkg::OP_BYTE:
                begin
                    if (phase_reg != PH_IDLE && pos_w < size_w)
                    begin
                        pos_next = pos_inc;
                        unique case (phase_reg)
                            PH_NAME:
                            begin
                                if (name_cnt_reg < 3'(ptbd_pkg::PREFIX_LEN))
                                begin
                                    if (item.byte_value != ptbd_pkg::sprite_char(name_cnt_reg))
                                        sprite_upd = 1'b0;
                                    if (item.byte_value != ptbd_pkg::weapon_char(name_cnt_reg))
                                        weapon_upd = 1'b0;
                                    name_cnt_inc = name_cnt_reg + 1'b1;
                                end
                                sprite_next    = sprite_upd;
                                weapon_next    = weapon_upd;
                                name_cnt_next  = name_cnt_inc;
                                field_rem_next = rem_dec;
                                if (rem_dec == '0)
                                begin
                                    transp_next = (name_cnt_inc == 3'(ptbd_pkg::PREFIX_LEN))
                                                  && (sprite_upd || weapon_upd);
                                    if (rem_lt2)
                                    begin
                                        job_valid   = 1'b1;
                                        job.has_end = 1'b1;
                                        job.status  = ptbd_pkg::ST_BAD_LENGTH;
                                        phase_next  = PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next     = PH_TCOUNT;
                                        field_rem_next = 16'd2;
                                    end
                                end
                            end
                            PH_TEXELS:
                            begin
                                job_valid       = 1'b1;
                                job.has_texel   = 1'b1;
                                job.addr        = item.byte_value;
                                job.zero_color  = (transp_reg && item.byte_value == 8'd0) ||
                                                  ({1'b0, item.byte_value} >=
                                                   9'(PALETTE_ENTRIES));
                                job.entry_index = parsed_reg;
                                job.texel_index = texel_cnt_reg;
                                texel_cnt_next  = texel_cnt_reg + 1'b1;
                                field_rem_next  = rem_dec;
                                if (rem_dec == '0)
                                begin
                                    job.entry_done    = 1'b1;
                                    parsed_next       = parsed_inc;
                                    job.entries_found = parsed_inc;
                                    priority if (parsed_inc >= expected_reg)
                                    begin
                                        job.has_end = 1'b1;
                                        job.status  = ptbd_pkg::ST_ALL_PARSED;
                                        phase_next  = PH_IDLE;
                                    end
                                    else if (pn_w >= size_w)
                                    begin
                                        job.has_end = 1'b1;
                                        job.status  = ptbd_pkg::ST_BLOB_ENDED;
                                        phase_next  = PH_IDLE;
                                    end
                                    else if (rem_lt2)
                                    begin
                                        job.has_end = 1'b1;
                                        job.status  = ptbd_pkg::ST_BAD_LENGTH;
                                        phase_next  = PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next     = PH_NAMELEN;
                                        field_rem_next = 16'd2;
                                    end
                                end
                            end
                            PH_MAGIC, PH_COUNT, PH_NAMELEN, PH_TCOUNT:
                            begin
                                if (field_rem_reg == 16'd2)
                                begin
                                    low_hold_next  = item.byte_value;
                                    field_rem_next = 16'd1;
                                end
                                else
                                begin
                                    field_rem_next = '0;
                                    priority if (phase_reg == PH_MAGIC)
                                    begin
                                        if (value != ptbd_pkg::CATALOG_MAGIC)
                                        begin
                                            job_valid   = 1'b1;
                                            job.has_end = 1'b1;
                                            job.status  = ptbd_pkg::ST_BAD_MAGIC;
                                            phase_next  = PH_IDLE;
                                        end
                                        else
                                        begin
                                            phase_next     = PH_COUNT;
                                            field_rem_next = 16'd2;
                                        end
                                    end
                                    else if (phase_reg == PH_COUNT)
                                    begin
                                        priority if (value == '0)
                                        begin
                                            job_valid   = 1'b1;
                                            job.has_end = 1'b1;
                                            job.status  = ptbd_pkg::ST_ZERO_COUNT;
                                            phase_next  = PH_IDLE;
                                        end
                                        else if (pn_w >= size_w)
                                        begin
                                            expected_next = value;
                                            job_valid     = 1'b1;
                                            job.has_end   = 1'b1;
                                            job.status    = ptbd_pkg::ST_BLOB_ENDED;
                                            phase_next    = PH_IDLE;
                                        end
                                        else if (rem_lt2)
                                        begin
                                            expected_next = value;
                                            job_valid     = 1'b1;
                                            job.has_end   = 1'b1;
                                            job.status    = ptbd_pkg::ST_BAD_LENGTH;
                                            phase_next    = PH_IDLE;
                                        end
                                        else
                                        begin
                                            expected_next  = value;
                                            phase_next     = PH_NAMELEN;
                                            field_rem_next = 16'd2;
                                        end
                                    end
                                    else
                                    begin
                                        // name length or texel count
                                        if (value == '0 || pn_w + CW'(value) > size_w)
                                        begin
                                            job_valid   = 1'b1;
                                            job.has_end = 1'b1;
                                            job.status  = ptbd_pkg::ST_BAD_LENGTH;
                                            phase_next  = PH_IDLE;
                                        end
                                        else if (phase_reg == PH_NAMELEN)
                                        begin
                                            field_rem_next = value;
                                            name_cnt_next  = '0;
                                            sprite_next    = 1'b1;
                                            weapon_next    = 1'b1;
                                            phase_next     = PH_NAME;
                                        end
                                        else
                                        begin
                                            field_rem_next = value;
                                            texel_cnt_next = '0;
                                            phase_next     = PH_TEXELS;
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            low_hold_reg  <= '0;
            field_rem_reg <= '0;
            expected_reg  <= '0;
            parsed_reg    <= '0;
            texel_cnt_reg <= '0;
            name_cnt_reg  <= '0;
            sprite_reg    <= 1'b1;
            weapon_reg    <= 1'b1;
            transp_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            low_hold_reg  <= low_hold_next;
            field_rem_reg <= field_rem_next;
            expected_reg  <= expected_next;
            parsed_reg    <= parsed_next;
            texel_cnt_reg <= texel_cnt_next;
            name_cnt_reg  <= name_cnt_next;
            sprite_reg    <= sprite_next;
            weapon_reg    <= weapon_next;
            transp_reg    <= transp_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ptbd_jobq.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptbd_jobq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire ptbd_pkg::job_t wr_job,
    output logic                full,
    input  wire logic           rd_en,
    output ptbd_pkg::job_t      rd_job,
    output logic                empty
);

    localparam int AW = $clog2(ptbd_pkg::JOBQ_DEPTH);

    ptbd_pkg::job_t slot_reg [ptbd_pkg::JOBQ_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           do_wr, do_rd;

    always_comb
    begin
        full        = (count_reg == (AW+1)'(ptbd_pkg::JOBQ_DEPTH));
        empty       = (count_reg == '0);
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        rd_job      = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/ptbd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptbd_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_empty,
    input  wire ptbd_pkg::job_t job,
    output logic                job_pop,
    output ptbd_pkg::out_item_t result,
    output logic                empty,
    input  wire logic           pop
);

    localparam int PAW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int QAW = $clog2(ptbd_pkg::OUTQ_DEPTH);

    logic [23:0] palette_mem [PALETTE_ENTRIES];

    logic                s2_valid_reg;
    ptbd_pkg::job_t      s2_job_reg;
    logic [23:0]         rd_data_reg;

    ptbd_pkg::out_item_t q_reg [ptbd_pkg::OUTQ_DEPTH];
    logic [QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]        count_reg, count_next;

    logic [QAW:0]        n_push;
    logic [QAW+1:0]      need;
    logic                do_pop;
    logic                s2_load;
    ptbd_pkg::out_item_t res_texel, res_end, res0, res1;
    logic [15:0]         color565;

    always_comb
    begin
        // results leaving stage two this cycle
        n_push = '0;
        if (s2_valid_reg)
            n_push = (QAW+1)'(s2_job_reg.has_texel) + (QAW+1)'(s2_job_reg.has_end);

        // a job leaves the queue only when two more results surely fit
        need    = (QAW+2)'(count_reg) + (QAW+2)'(n_push) + (QAW+2)'(2);
        job_pop = !job_empty && (need <= (QAW+2)'(ptbd_pkg::OUTQ_DEPTH));
        s2_load = job_pop && (job.has_texel || job.has_end);

        color565 = s2_job_reg.zero_color ? 16'd0 :
                   {rd_data_reg[23:19], rd_data_reg[15:10], rd_data_reg[7:3]};

        res_texel               = '0;
        res_texel.kind          = ptbd_pkg::KIND_TEXEL;
        res_texel.color         = color565;
        res_texel.entry_index   = s2_job_reg.entry_index;
        res_texel.texel_index   = s2_job_reg.texel_index;
        res_texel.entry_done    = s2_job_reg.entry_done;
        res_texel.last_of_run   = !s2_job_reg.has_end;

        res_end                 = '0;
        res_end.kind            = ptbd_pkg::KIND_END;
        res_end.status          = s2_job_reg.status;
        res_end.entries_found   = s2_job_reg.entries_found;
        res_end.last_of_run     = 1'b1;

        res0 = s2_job_reg.has_texel ? res_texel : res_end;
        res1 = res_end;

        empty       = (count_reg == '0);
        do_pop      = pop && !empty;
        result      = q_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg + QAW'(n_push);
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + n_push - (QAW+1)'(do_pop);
    end

    // palette memory: one access per job, read data registered
    always_ff @(posedge clk)
    begin
        if (job_pop && job.is_write)
            palette_mem[job.addr[PAW-1:0]] <= job.rgb;
        if (s2_load)
            rd_data_reg <= palette_mem[job.addr[PAW-1:0]];
        if (s2_load)
            s2_job_reg <= job;
    end

    always_ff @(posedge clk)
    begin
        if (n_push != '0)
            q_reg[wr_ptr_reg] <= res0;
        if (n_push == (QAW+1)'(2))
            q_reg[wr_ptr_reg + 1'b1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s2_valid_reg <= s2_load;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/palette_texture_blob_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// palette texture blob decoder: items come in through a queue-style port
// (push/full) and results leave through one (empty/pop). operation 0 writes
// an rgb888 palette entry, 1 starts a new blob, 2 feeds the next blob byte.
// the parser front end takes one item per clock while the job queue is not
// full and hands palette writes and texel lookups to the back end through a
// four-deep job queue; the back end reads the single-port palette memory
// (one access per job, read data registered), turns the entry into rgb565
// and places up to two results per transaction into an eight-deep result
// queue. sustained rate is one item per cycle as long as results are popped;
// a result is held in stage two, then in the result queue. blob_bytes
// (address 0, bits 19:0) must only be written while no parse results are
// pending. palette entries read before they are written return undefined
// colors. the end result always carries last_of_run, and a texel that
// finishes the final entry is followed by its end result from the same
// transaction.
module palette_texture_blob_decoder #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int POSITION_BITS   = 20
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // item queue side
    input  wire logic                push,
    output logic                     full,
    input  wire ptbd_pkg::in_item_t  item,
    // result queue side
    output logic                     empty,
    input  wire logic                pop,
    output ptbd_pkg::out_item_t      result,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [ptbd_pkg::BLOB_BYTES_W-1:0] blob_bytes_reg, blob_bytes_next;
    logic                              cfg_wr;

    logic           accept;
    ptbd_pkg::job_t front_job;
    logic           front_job_valid;
    ptbd_pkg::job_t head_job;
    logic           jobq_empty;
    logic           jobq_pop;

    // register 0 sits at byte address 0; anything at address 4 is ignored
    always_comb
    begin
        pready          = 1'b1;
        cfg_wr          = psel && penable && pwrite && pready && !paddr[2];
        blob_bytes_next = cfg_wr ? pwdata[ptbd_pkg::BLOB_BYTES_W-1:0] : blob_bytes_reg;
        prdata          = (psel && !paddr[2]) ? 32'(blob_bytes_reg) : '0;
        accept          = push && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blob_bytes_reg <= '0;
        else
            blob_bytes_reg <= blob_bytes_next;
    end

    // parser: byte position, field counters, prefix match
    ptbd_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .POSITION_BITS   (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .blob_bytes (blob_bytes_reg),
        .job        (front_job),
        .job_valid  (front_job_valid)
    );

    // decouples the parser from palette lookups and result backpressure
    ptbd_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_job_valid),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (jobq_pop),
        .rd_job (head_job),
        .empty  (jobq_empty)
    );

    // palette memory, color conversion, result queue
    ptbd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (jobq_empty),
        .job       (head_job),
        .job_pop   (jobq_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // an end-of-parse result always closes its transaction
    a_end_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == ptbd_pkg::KIND_END) |-> result.last_of_run
    ) else $error("end result without last_of_run");

    // texel results carry no parse summary
    a_texel_no_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == ptbd_pkg::KIND_TEXEL) |->
            (result.status == ptbd_pkg::ST_ALL_PARSED && result.entries_found == 16'd0)
    ) else $error("texel result carries end fields");

    // a completed write to address 0 lands in blob_bytes
    a_cfg_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) |=>
            (blob_bytes_reg == $past(pwdata[ptbd_pkg::BLOB_BYTES_W-1:0]))
    ) else $error("blob_bytes write lost");

endmodule

`default_nettype wire

/* dv/tb_palette_texture_blob_decoder.sv */
`timescale 1ns / 1ps

module tb_palette_texture_blob_decoder;

    // register map and unused operation code
    localparam logic [2:0] BLOB_BYTES_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR      = 3'd4;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    localparam int ITEM_TARGET   = 1300;
    localparam int IDLE_PCT      = 29;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 4000;

    // parser position inside the blob layout
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_MAGIC,
        SCAN_COUNT,
        SCAN_NAMELEN,
        SCAN_NAME,
        SCAN_TCOUNT,
        SCAN_TEXELS
    } scan_phase_t;

    // predicts texels and parse ends from accepted transactions, checks results
    class texel_stream_board;
        logic [23:0] palette [256];
        bit          written [256];
        logic [19:0] span;
        scan_phase_t phase;
        logic [19:0] pos;
        logic [7:0]  low_half;
        logic [15:0] remaining;
        logic [15:0] entries_declared;
        logic [15:0] entries_done;
        logic [15:0] texel_no;
        logic [2:0]  name_seen;
        bit          sprite_ok;
        bit          weapon_ok;
        bit          see_through;
        ptbd_pkg::out_item_t awaited [$];
        ptbd_pkg::out_item_t fresh [$];
        string       sprite_tag;
        string       weapon_tag;
        int          errors;
        int          n_results;
        int          n_texels;
        int          n_ends;
        logic [5:0]  status_seen;

        function new();
            foreach (written[i]) written[i] = 1'b0;
            span        = '0;
            phase       = SCAN_IDLE;
            pos         = '0;
            low_half    = '0;
            remaining   = '0;
            entries_declared = '0;
            entries_done = '0;
            texel_no    = '0;
            name_seen   = '0;
            sprite_ok   = 1'b1;
            weapon_ok   = 1'b1;
            see_through = 1'b0;
            sprite_tag  = "sprite_";
            weapon_tag  = "weapon_";
            errors      = 0;
            n_results   = 0;
            n_texels    = 0;
            n_ends      = 0;
            status_seen = '0;
        endfunction

        task report(input string msg);
            $display("MISMATCH %s", msg);
            errors++;
        endtask

        function int pending();
            return awaited.size();
        endfunction

        function void write_register(input logic [2:0] addr, input logic [31:0] data);
            if (addr == BLOB_BYTES_ADDR)
                span = data[19:0];
        endfunction

        function void close_parse(input logic [2:0] st);
            ptbd_pkg::out_item_t t;
            t = '0;
            t.kind = ptbd_pkg::KIND_END;
            t.status = st;
            t.entries_found = entries_done;
            fresh.push_back(t);
            phase = SCAN_IDLE;
        endfunction

        function void open_field(input scan_phase_t p);
            phase = p;
            remaining = 16'd2;
        endfunction

        // after the count or a finished entry
        function void entry_boundary();
            if (pos >= span)
                close_parse(ptbd_pkg::ST_BLOB_ENDED);
            else if (int'(span) - int'(pos) < 2)
                close_parse(ptbd_pkg::ST_BAD_LENGTH);
            else
                open_field(SCAN_NAMELEN);
        endfunction

        function bit overruns(input logic [15:0] n);
            return n == 16'd0 || int'(pos) + int'(n) > int'(span);
        endfunction

        function logic [15:0] rgb565(input logic [7:0] idx);
            logic [23:0] c;
            if (see_through && idx == 8'd0)
                return 16'd0;
            c = palette[idx];
            return {c[23:19], c[15:10], c[7:3]};
        endfunction

        function void take_byte(input logic [7:0] b);
            ptbd_pkg::out_item_t t;
            logic [15:0] word;
            if (phase == SCAN_IDLE || pos >= span)
                return;
            pos = pos + 20'd1;
            case (phase)
                SCAN_NAME: begin
                    if (name_seen < 3'd7) begin
                        if (b != sprite_tag[name_seen]) sprite_ok = 1'b0;
                        if (b != weapon_tag[name_seen]) weapon_ok = 1'b0;
                        name_seen = name_seen + 3'd1;
                    end
                    remaining = remaining - 16'd1;
                    if (remaining == 16'd0) begin
                        see_through = (name_seen == 3'd7) && (sprite_ok || weapon_ok);
                        if (int'(span) - int'(pos) < 2)
                            close_parse(ptbd_pkg::ST_BAD_LENGTH);
                        else
                            open_field(SCAN_TCOUNT);
                    end
                end
                SCAN_TEXELS: begin
                    t = '0;
                    t.kind = ptbd_pkg::KIND_TEXEL;
                    t.color = rgb565(b);
                    t.entry_index = entries_done;
                    t.texel_index = texel_no;
                    texel_no = texel_no + 16'd1;
                    remaining = remaining - 16'd1;
                    if (remaining == 16'd0) begin
                        t.entry_done = 1'b1;
                        fresh.push_back(t);
                        entries_done = entries_done + 16'd1;
                        if (entries_done >= entries_declared)
                            close_parse(ptbd_pkg::ST_ALL_PARSED);
                        else
                            entry_boundary();
                    end
                    else
                        fresh.push_back(t);
                end
                default: begin
                    // little-endian 16-bit fields
                    if (remaining == 16'd2) begin
                        low_half = b;
                        remaining = 16'd1;
                        return;
                    end
                    word = {b, low_half};
                    remaining = 16'd0;
                    case (phase)
                        SCAN_MAGIC:
                            if (word != ptbd_pkg::CATALOG_MAGIC)
                                close_parse(ptbd_pkg::ST_BAD_MAGIC);
                            else open_field(SCAN_COUNT);
                        SCAN_COUNT:
                            if (word == 16'd0) close_parse(ptbd_pkg::ST_ZERO_COUNT);
                            else begin
                                entries_declared = word;
                                entry_boundary();
                            end
                        SCAN_NAMELEN:
                            if (overruns(word)) close_parse(ptbd_pkg::ST_BAD_LENGTH);
                            else begin
                                remaining = word;
                                name_seen = '0;
                                sprite_ok = 1'b1;
                                weapon_ok = 1'b1;
                                phase = SCAN_NAME;
                            end
                        default:
                            if (overruns(word)) close_parse(ptbd_pkg::ST_BAD_LENGTH);
                            else begin
                                remaining = word;
                                texel_no = '0;
                                phase = SCAN_TEXELS;
                            end
                    endcase
                end
            endcase
        endfunction

        function void note_item(input ptbd_pkg::in_item_t it);
            ptbd_pkg::out_item_t tail;
            fresh.delete();
            case (it.operation)
                ptbd_pkg::OP_PALETTE: begin
                    palette[it.palette_index] = {it.red, it.green, it.blue};
                    written[it.palette_index] = 1'b1;
                end
                ptbd_pkg::OP_START: begin
                    pos = '0;
                    low_half = '0;
                    remaining = '0;
                    entries_declared = '0;
                    entries_done = '0;
                    texel_no = '0;
                    name_seen = '0;
                    sprite_ok = 1'b1;
                    weapon_ok = 1'b1;
                    see_through = 1'b0;
                    if (span < 20'd4)
                        close_parse(ptbd_pkg::ST_SHORT);
                    else
                        open_field(SCAN_MAGIC);
                end
                ptbd_pkg::OP_BYTE: take_byte(it.byte_value);
                default: ;
            endcase
            if (fresh.size() != 0) begin
                tail = fresh.pop_back();
                tail.last_of_run = 1'b1;
                fresh.push_back(tail);
            end
            foreach (fresh[i]) awaited.push_back(fresh[i]);
        endfunction

        task check_result(input ptbd_pkg::out_item_t got);
            ptbd_pkg::out_item_t want;
            string diff;
            n_results++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d with nothing expected: %p", n_results, got));
                return;
            end
            want = awaited.pop_front();
            diff = "";
            if (got.kind !== want.kind) diff = {diff, " kind"};
            if (got.color !== want.color) diff = {diff, " color"};
            if (got.entry_index !== want.entry_index) diff = {diff, " entry_index"};
            if (got.texel_index !== want.texel_index) diff = {diff, " texel_index"};
            if (got.entry_done !== want.entry_done) diff = {diff, " entry_done"};
            if (got.status !== want.status) diff = {diff, " status"};
            if (got.entries_found !== want.entries_found) diff = {diff, " entries_found"};
            if (got.last_of_run !== want.last_of_run) diff = {diff, " last_of_run"};
            if (diff != "")
                report($sformatf("result %0d differs in%s: got %p, expected %p",
                                 n_results, diff, got, want));
            else if (want.kind == ptbd_pkg::KIND_END) begin
                n_ends++;
                status_seen[want.status] = 1'b1;
            end
            else
                n_texels++;
        endtask

        // a byte that lands on a texel must name a written palette entry
        // unless it is the transparent index
        function logic [7:0] safe_byte(input logic [7:0] b);
            logic [7:0] pick;
            if (phase != SCAN_TEXELS || pos >= span || written[b] || (see_through && b == 8'd0))
                return b;
            do pick = 8'($urandom); while (!written[pick]);
            return pick;
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    ptbd_pkg::in_item_t item = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        full;
    logic        empty;
    logic        pready;
    logic [31:0] prdata;
    ptbd_pkg::out_item_t result;

    texel_stream_board board = new();

    // stimulus control shared between processes
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    int          n_sent = 0;
    int          n_blobs = 0;
    int          n_settings = 0;
    int          quiet_cycles = 0;
    int          full_run = 0;
    int          longest_full = 0;
    logic [7:0]  blob_q [$];

    always #6 clk = ~clk;

    palette_texture_blob_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // monitor: inputs are stable here since they only move on the falling edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_item(item);
            if (pop && !empty)
                board.check_result(result);
        end
    end

    // watchdog on cycles with no transaction on any port, plus input stall length
    always @(posedge clk)
    begin
        if (push && full)
            full_run++;
        else
            full_run = 0;
        if (full_run > longest_full)
            longest_full = full_run;
        if ((push && !full) || (pop && !empty) || (psel && penable && pready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, board.pending());
                $display("tb_palette_texture_blob_decoder: done, errors");
                $finish;
            end
        end
    end

    // result side: random pops, with a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic ptbd_pkg::in_item_t rand_item(input logic [1:0] op);
        ptbd_pkg::in_item_t it;
        it.operation     = op;
        it.byte_value    = 8'($urandom);
        it.palette_index = 8'($urandom);
        it.red           = 8'($urandom);
        it.green         = 8'($urandom);
        it.blue          = 8'($urandom);
        return it;
    endfunction

    function automatic void add_u16(input logic [15:0] v);
        blob_q.push_back(v[7:0]);
        blob_q.push_back(v[15:8]);
    endfunction

    // name bytes: often a transparency prefix, sometimes with one broken character
    function automatic void add_name(input int nlen);
        string tag;
        int p;
        int bad;
        p = $urandom_range(99);
        if (p < 35)
            tag = "sprite_";
        else if (p < 70)
            tag = "weapon_";
        else
            tag = "";
        bad = ($urandom_range(99) < 15) ? $urandom_range(0, 6) : -1;
        for (int i = 0; i < nlen; i++)
        begin
            if (i < tag.len() && i != bad)
                blob_q.push_back(tag[i]);
            else if (i < tag.len())
                blob_q.push_back(8'(tag[i] ^ 8'h01));
            else
                blob_q.push_back(8'($urandom));
        end
    endfunction

    // one blob, mostly well formed, plus the blob length to run it under
    function automatic void build_blob(input bit rich, output logic [19:0] span,
                                       output bit rewrite);
        int n_built;
        int n_declared;
        int nlen;
        int ntex;
        int p;
        int total;
        blob_q.delete();
        rewrite = 1'b1;
        add_u16(($urandom_range(99) < 92) ? ptbd_pkg::CATALOG_MAGIC : 16'($urandom));
        n_built = rich ? 3 : $urandom_range(1, 3);
        p = $urandom_range(99);
        if (rich || p < 62)
            n_declared = n_built;
        else if (p < 70)
            n_declared = 0;
        else if (p < 88)
            n_declared = n_built + $urandom_range(1, 2);
        else if (p < 96)
            n_declared = n_built - 1;
        else
            n_declared = 16'hffff;
        add_u16(16'(n_declared));
        for (int e = 0; e < n_built; e++)
        begin
            p = $urandom_range(99);
            if (rich)
                nlen = $urandom_range(1, 10);
            else if (p < 3)
                nlen = 0;
            else if (p < 5)
                nlen = 16'hffff;
            else
                nlen = $urandom_range(1, 11);
            add_u16(16'(nlen));
            if (nlen == 0 || nlen > 11)
                break;
            add_name(nlen);
            p = $urandom_range(99);
            if (rich)
                ntex = 8;
            else if (p < 3)
                ntex = 0;
            else if (p < 5)
                ntex = 16'hffff;
            else
                ntex = $urandom_range(1, 8);
            add_u16(16'(ntex));
            if (ntex == 0 || ntex > 8)
                break;
            repeat (ntex)
                blob_q.push_back(($urandom_range(99) < 30) ? 8'h00 : 8'($urandom));
        end
        // exact fit, one spare byte, loose, truncated, maximum, tiny, or unchanged
        total = blob_q.size();
        p = $urandom_range(99);
        if (rich || p < 45)
            span = 20'(total);
        else if (p < 55)
            span = 20'(total + 1);
        else if (p < 67)
            span = 20'(total + $urandom_range(2, 30));
        else if (p < 77)
            span = 20'($urandom_range(4, total - 1));
        else if (p < 83)
            span = 20'hfffff;
        else if (p < 90)
            span = 20'($urandom_range(0, 4));
        else
        begin
            span = board.span;
            rewrite = 1'b0;
        end
    endfunction

    // offer one transaction; returns at the edge that accepts it
    task automatic offer(input ptbd_pkg::in_item_t it);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        if (it.operation == ptbd_pkg::OP_BYTE)
            it.byte_value = board.safe_byte(it.byte_value);
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        if (it.operation != OP_UNUSED)
            n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        ptbd_pkg::in_item_t it;
        it = rand_item(ptbd_pkg::OP_BYTE);
        it.byte_value = b;
        offer(it);
    endtask

    // blob bytes, optionally mixed with palette writes, unused codes and restarts
    task automatic send_blob(input bit noisy);
        int p;
        foreach (blob_q[i])
        begin
            p = $urandom_range(999);
            if (noisy && p < 50)
                offer(rand_item(ptbd_pkg::OP_PALETTE));
            else if (noisy && p < 70)
                offer(rand_item(OP_UNUSED));
            else if (noisy && p < 73)
                offer(rand_item(ptbd_pkg::OP_START));
            send_byte(blob_q[i]);
        end
    endtask

    // stop sending and wait for every expected result plus the pipeline tail
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write, then read blob_bytes back
    task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.write_register(addr, data);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= BLOB_BYTES_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== 32'(board.span))
            board.report($sformatf("blob_bytes reads %h, expected %h", prdata, board.span));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        ptbd_pkg::in_item_t it;
        logic [19:0] span;
        bit          rewrite;
        string       nm;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: palette extremes, index 0 kept visible so transparency shows
        it = rand_item(ptbd_pkg::OP_PALETTE);
        it.palette_index = 8'h00;
        {it.red, it.green, it.blue} = 24'hffffff;
        offer(it);
        it.palette_index = 8'hff;
        {it.red, it.green, it.blue} = 24'h000000;
        offer(it);
        it.palette_index = 8'h5a;
        {it.red, it.green, it.blue} = 24'ha55ac3;
        offer(it);
        // unused code and a byte while idle do nothing
        it = rand_item(OP_UNUSED);
        it.byte_value = 8'hff;
        offer(it);
        send_byte(8'hff);
        // start with blob_bytes still at its reset value: short blob
        offer(rand_item(ptbd_pkg::OP_START));

        // one complete weapon_ entry; the last texel and the end share a transaction
        drain();
        set_register(BLOB_BYTES_ADDR, 32'd18);
        n_settings++;
        blob_q.delete();
        add_u16(ptbd_pkg::CATALOG_MAGIC);
        add_u16(16'd1);
        add_u16(16'd7);
        nm = "weapon_";
        for (int i = 0; i < nm.len(); i++)
            blob_q.push_back(nm[i]);
        add_u16(16'd3);
        blob_q.push_back(8'h00);
        blob_q.push_back(8'h5a);
        blob_q.push_back(8'hff);
        offer(rand_item(ptbd_pkg::OP_START));
        send_blob(1'b0);

        // random blobs, one blob_bytes setting per blob where it changes
        while (n_sent < ITEM_TARGET)
        begin
            n_blobs++;
            steady = (n_blobs >= 10 && n_blobs < 16);
            build_blob(n_blobs == 4 || n_blobs == 22, span, rewrite);
            if (rewrite)
            begin
                drain();
                if ($urandom_range(99) < 8)
                    set_register(SPARE_ADDR, $urandom);
                set_register(BLOB_BYTES_ADDR, 32'(span));
                n_settings++;
                // stray bytes against whatever parse was left open
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
            // receiver stalls long enough for both queues to fill
            if (n_blobs == 4 || n_blobs == 22)
                hold_req = 1'b1;
            offer(rand_item(ptbd_pkg::OP_START));
            send_blob(1'b1);
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end

        drain();
        $display("covered %0d transactions over %0d blobs and %0d blob_bytes settings",
                 n_sent, n_blobs, n_settings);
        $display("checked %0d results: %0d texels, %0d parse ends, status mask %06b, %s",
                 board.n_results, board.n_texels, board.n_ends, board.status_seen,
                 $sformatf("input stall up to %0d cycles", longest_full));
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_palette_texture_blob_decoder: done, clean");
        else
            $display("tb_palette_texture_blob_decoder: done, errors");
        $finish;
    end

endmodule
